FILE: rtl/sfom_pkg.sv
// Shared widths, codes and item types of the striped file offset mapper.
package sfom_pkg;

    localparam int OFF_W     = 63;
    localparam int LEN_W     = 32;
    localparam int DEN_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_UNIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE    = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_MAPPED     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EOF        = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_LAYOUT = 2'd2;

    typedef struct packed {
        logic [DEN_W-1:0] su;
        logic [DEN_W-1:0] sc;
        logic [DEN_W-1:0] os;
        logic [OFF_W-1:0] fs;
    } cfg_t;

    typedef struct packed {
        logic             eof;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] run1;
    } front_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  objno;
        logic [DEN_W-1:0]  objoff;
        logic [LEN_W-1:0]  run;
    } result_t;

endpackage

FILE: rtl/striped_file_offset_mapper.sv
// Top level of the striped file offset mapper: config registers and the two halves.
//
//  channel   handshake              payload
//  request   push / full            byte_offset, request_length
//  result    pop / empty            status, object_number, object_offset, run_length
//  config    cfg_write              cfg_index, cfg_data
//
// One item enters per cycle and one result leaves per cycle when nothing stalls.
// The back end is three chained 63-stage pipelined dividers (block, stripe, object set)
// and one product stage, between the two queues.
// Reset clears the queues and the stage valid bits; config returns to its defaults.
// A full result queue freezes the back end while its last stage holds a result; the
// four-entry request queue keeps taking items until it fills too.
module striped_file_offset_mapper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [sfom_pkg::OFF_W-1:0]      byte_offset,
    input  logic [sfom_pkg::LEN_W-1:0]      request_length,
    output logic                            empty,
    input  logic                            pop,
    output logic [sfom_pkg::STAT_W-1:0]     status,
    output logic [sfom_pkg::OFF_W-1:0]      object_number,
    output logic [sfom_pkg::DEN_W-1:0]      object_offset,
    output logic [sfom_pkg::LEN_W-1:0]      run_length,
    input  logic                            cfg_write,
    input  logic [sfom_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfom_pkg::OFF_W-1:0]      cfg_data
);
    import sfom_pkg::*;

    cfg_t    cfg_reg;
    logic    q_valid, deq, res_full, res_push;
    front_t  q_item;
    result_t res_item, out_item;

    // Take a config write at once; the layout must only change while idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.su <= DEN_W'(4194304);
            cfg_reg.sc <= DEN_W'(1);
            cfg_reg.os <= DEN_W'(4194304);
            cfg_reg.fs <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_STRIPE_UNIT:  cfg_reg.su <= cfg_data[DEN_W-1:0];
                REG_STRIPE_COUNT: cfg_reg.sc <= cfg_data[DEN_W-1:0];
                REG_OBJECT_SIZE:  cfg_reg.os <= cfg_data[DEN_W-1:0];
                REG_FILE_SIZE:    cfg_reg.fs <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Front: classify and queue the request.
    sfom_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .byte_offset(byte_offset), .request_length(request_length),
        .file_size(cfg_reg.fs), .deq(deq), .q_valid(q_valid), .q_item(q_item)
    );

    // Back: divide the offset down to object and position, then clamp the run.
    sfom_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .in_valid(q_valid), .in_item(q_item),
        .deq(deq), .res_full(res_full), .res_push(res_push), .res_item(res_item)
    );

    // Results wait here until popped.
    sfom_resq u_resq (
        .clk(clk), .rst_n(rst_n), .wr(res_push), .wr_item(res_item), .full(res_full),
        .empty(empty), .pop(pop), .rd_item(out_item)
    );

    assign status        = out_item.status;
    assign object_number = out_item.objno;
    assign object_offset = out_item.objoff;
    assign run_length    = out_item.run;

endmodule

FILE: rtl/sfom_front.sv
// Front end: accept requests, flag end of file, pre-clamp the run, queue them.
module sfom_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [sfom_pkg::OFF_W-1:0] byte_offset,
    input  logic [sfom_pkg::LEN_W-1:0] request_length,
    input  logic [sfom_pkg::OFF_W-1:0] file_size,
    input  logic                  deq,
    output logic                  q_valid,
    output sfom_pkg::front_t      q_item
);
    import sfom_pkg::*;

    front_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    cnt_reg, cnt_next;
    logic [OFF_W-1:0]   left;
    front_t             cls;
    logic               accept, take;

    // Classify: end of file, and clamp the length to what is left of the file.
    always_comb
    begin
        left     = file_size - byte_offset;
        cls.eof  = byte_offset >= file_size;
        cls.off  = byte_offset;
        if (left[OFF_W-1:LEN_W] != '0 || request_length <= left[LEN_W-1:0])
            cls.run1 = request_length;
        else
            cls.run1 = left[LEN_W-1:0];
    end

    assign full    = cnt_reg == (QPTR_W+1)'(QDEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_item  = mem_reg[rd_ptr_reg];
    assign accept  = push && !full;
    assign take    = deq && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !take)
            cnt_next = cnt_reg + 1'b1;
        else if (take && !accept)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (take)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            mem_reg[wr_ptr_reg] <= cls;
    end

endmodule

FILE: rtl/sfom_div.sv
// Pipelined restoring divider: one quotient bit per stage.
module sfom_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [sfom_pkg::OFF_W-1:0] dividend,
    input  logic [sfom_pkg::DEN_W-1:0] divisor,
    output logic [sfom_pkg::OFF_W-1:0] quotient,
    output logic [sfom_pkg::DEN_W-1:0] remainder
);
    import sfom_pkg::*;

    logic [OFF_W-1:0] num_reg [OFF_W];
    logic [OFF_W-1:0] quo_reg [OFF_W];
    logic [DEN_W-1:0] rem_reg [OFF_W];
    logic [OFF_W-1:0] num_next [OFF_W];
    logic [OFF_W-1:0] quo_next [OFF_W];
    logic [DEN_W-1:0] rem_next [OFF_W];

    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] r,
                                                input logic b,
                                                input logic [DEN_W-1:0] d);
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        begin
            t    = {r, b};
            diff = t - {1'b0, d};
            if (t >= {1'b0, d})
                div_step = {1'b1, diff[DEN_W-1:0]};
            else
                div_step = {1'b0, t[DEN_W-1:0]};
        end
    endfunction

    always_comb
    begin
        logic [DEN_W:0] st;
        st          = div_step('0, dividend[OFF_W-1], divisor);
        num_next[0] = dividend;
        quo_next[0] = {{(OFF_W-1){1'b0}}, st[DEN_W]};
        rem_next[0] = st[DEN_W-1:0];
        for (int s = 1; s < OFF_W; s++)
        begin
            st          = div_step(rem_reg[s-1], num_reg[s-1][OFF_W-1-s], divisor);
            num_next[s] = num_reg[s-1];
            quo_next[s] = {quo_reg[s-1][OFF_W-2:0], st[DEN_W]};
            rem_next[s] = st[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < OFF_W; s++)
            begin
                num_reg[s] <= num_next[s];
                quo_reg[s] <= quo_next[s];
                rem_reg[s] <= rem_next[s];
            end
        end
    end

    assign quotient  = quo_reg[OFF_W-1];
    assign remainder = rem_reg[OFF_W-1];

endmodule

FILE: rtl/sfom_back.sv
// Back end: three chained divisions, the products, the final clamps.
module sfom_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sfom_pkg::cfg_t    cfg,
    input  logic              in_valid,
    input  sfom_pkg::front_t  in_item,
    output logic              deq,
    input  logic              res_full,
    output logic              res_push,
    output sfom_pkg::result_t res_item
);
    import sfom_pkg::*;

    logic             en;
    logic [DEN_W-1:0] scx;

    // stage lines beside the dividers
    logic             a_valid_reg [OFF_W];
    logic             a_eof_reg   [OFF_W];
    logic [LEN_W-1:0] a_run1_reg  [OFF_W];
    logic             b_valid_reg [OFF_W];
    logic             b_eof_reg   [OFF_W];
    logic             b_ok_reg    [OFF_W];
    logic [LEN_W-1:0] b_run1_reg  [OFF_W];
    logic [DEN_W-1:0] b_boff_reg  [OFF_W];
    logic             c_valid_reg [OFF_W];
    logic             c_eof_reg   [OFF_W];
    logic             c_ok_reg    [OFF_W];
    logic [LEN_W-1:0] c_run1_reg  [OFF_W];
    logic [DEN_W-1:0] c_boff_reg  [OFF_W];
    logic [DEN_W-1:0] c_spos_reg  [OFF_W];

    logic [OFF_W-1:0] qa, qu, qb, qc;
    logic [DEN_W-1:0] ra, ru, rb, rc;
    logic [DEN_W-1:0] upo_reg;
    logic             a_ok;

    logic             m1_valid_reg, m1_eof_reg, m1_ok_reg;
    logic [63:0]      lo_prod_reg;
    logic [OFF_W-1:0] hi_prod_reg;
    logic [DEN_W-1:0] pos_prod_reg;
    logic [LEN_W-1:0] m1_run_reg;
    logic [DEN_W-1:0] m1_boff_reg, m1_spos_reg;

    logic [63:0]      lo_prod_next;
    logic [OFF_W-1:0] hi_prod_next;
    logic [63:0]      pos_prod_full;
    logic [DEN_W-1:0] unit_left;
    logic [LEN_W-1:0] run_next;

    // Freeze the whole back end while the last result cannot leave.
    assign en  = !(m1_valid_reg && res_full);
    assign deq = en;
    assign scx = (cfg.sc == '0) ? DEN_W'(1) : cfg.sc;

    sfom_div u_div_blk (.clk(clk), .en(en), .dividend(in_item.off), .divisor(cfg.su),
                        .quotient(qa), .remainder(ra));
    sfom_div u_div_upo (.clk(clk), .en(en), .dividend({{(OFF_W-DEN_W){1'b0}}, cfg.os}),
                        .divisor(cfg.su), .quotient(qu), .remainder(ru));
    sfom_div u_div_str (.clk(clk), .en(en), .dividend(qa), .divisor(scx),
                        .quotient(qb), .remainder(rb));
    sfom_div u_div_set (.clk(clk), .en(en), .dividend(qb), .divisor(upo_reg),
                        .quotient(qc), .remainder(rc));

    assign a_ok = (cfg.su != '0) && (cfg.os != '0) && (ru == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < OFF_W; s++)
            begin
                a_valid_reg[s] <= 1'b0;
                b_valid_reg[s] <= 1'b0;
                c_valid_reg[s] <= 1'b0;
            end
            m1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg[0] <= in_valid;
            b_valid_reg[0] <= a_valid_reg[OFF_W-1];
            c_valid_reg[0] <= b_valid_reg[OFF_W-1];
            for (int s = 1; s < OFF_W; s++)
            begin
                a_valid_reg[s] <= a_valid_reg[s-1];
                b_valid_reg[s] <= b_valid_reg[s-1];
                c_valid_reg[s] <= c_valid_reg[s-1];
            end
            m1_valid_reg <= c_valid_reg[OFF_W-1];
        end
    end

    always_comb
    begin
        lo_prod_next  = {32'b0, qc[31:0]} * {32'b0, scx};
        hi_prod_next  = {32'b0, qc[OFF_W-1:32]} * {{(OFF_W-DEN_W){1'b0}}, scx};
        pos_prod_full = {32'b0, rc} * {32'b0, cfg.su};
        unit_left     = cfg.su - c_boff_reg[OFF_W-1];
        run_next      = (unit_left < c_run1_reg[OFF_W-1]) ? unit_left : c_run1_reg[OFF_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Hold the stripe units per object; it only changes with the layout.
            if (a_valid_reg[OFF_W-1])
                upo_reg <= qu[DEN_W-1:0];

            a_eof_reg[0]  <= in_item.eof;
            a_run1_reg[0] <= in_item.run1;
            b_eof_reg[0]  <= a_eof_reg[OFF_W-1];
            b_ok_reg[0]   <= a_ok;
            b_run1_reg[0] <= a_run1_reg[OFF_W-1];
            b_boff_reg[0] <= ra;
            c_eof_reg[0]  <= b_eof_reg[OFF_W-1];
            c_ok_reg[0]   <= b_ok_reg[OFF_W-1];
            c_run1_reg[0] <= b_run1_reg[OFF_W-1];
            c_boff_reg[0] <= b_boff_reg[OFF_W-1];
            c_spos_reg[0] <= rb;
            for (int s = 1; s < OFF_W; s++)
            begin
                a_eof_reg[s]  <= a_eof_reg[s-1];
                a_run1_reg[s] <= a_run1_reg[s-1];
                b_eof_reg[s]  <= b_eof_reg[s-1];
                b_ok_reg[s]   <= b_ok_reg[s-1];
                b_run1_reg[s] <= b_run1_reg[s-1];
                b_boff_reg[s] <= b_boff_reg[s-1];
                c_eof_reg[s]  <= c_eof_reg[s-1];
                c_ok_reg[s]   <= c_ok_reg[s-1];
                c_run1_reg[s] <= c_run1_reg[s-1];
                c_boff_reg[s] <= c_boff_reg[s-1];
                c_spos_reg[s] <= c_spos_reg[s-1];
            end

            m1_eof_reg   <= c_eof_reg[OFF_W-1];
            m1_ok_reg    <= c_ok_reg[OFF_W-1];
            lo_prod_reg  <= lo_prod_next;
            hi_prod_reg  <= hi_prod_next;
            pos_prod_reg <= pos_prod_full[DEN_W-1:0];
            m1_run_reg   <= run_next;
            m1_boff_reg  <= c_boff_reg[OFF_W-1];
            m1_spos_reg  <= c_spos_reg[OFF_W-1];
        end
    end

    always_comb
    begin
        res_item = '0;
        if (m1_eof_reg)
            res_item.status = STATUS_EOF;
        else if (!m1_ok_reg)
            res_item.status = STATUS_BAD_LAYOUT;
        else
        begin
            res_item.status = STATUS_MAPPED;
            res_item.objno  = {hi_prod_reg[OFF_W-33:0], 32'b0} + lo_prod_reg[OFF_W-1:0]
                              + {{(OFF_W-DEN_W){1'b0}}, m1_spos_reg};
            res_item.objoff = pos_prod_reg + m1_boff_reg;
            res_item.run    = m1_run_reg;
        end
    end

    assign res_push = m1_valid_reg && !res_full;

`ifndef ASSERT_OFF
    a_run_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res_item.status == STATUS_MAPPED |-> res_item.run <= cfg.su)
        else $error("run exceeds stripe unit");
    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res_item.status != STATUS_MAPPED |->
        res_item.objno == '0 && res_item.objoff == '0 && res_item.run == '0)
        else $error("unmapped result carries data");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(m1_valid_reg) && $stable(m1_run_reg))
        else $error("last stage moved while stalled");
`endif

endmodule

FILE: rtl/sfom_resq.sv
// Result queue: parts the back end from the result consumer.
module sfom_resq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  sfom_pkg::result_t wr_item,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output sfom_pkg::result_t rd_item
);
    import sfom_pkg::*;

    result_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              take;

    assign full    = cnt_reg == (QPTR_W+1)'(QDEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_item = mem_reg[rd_ptr_reg];
    assign take    = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !take)
            cnt_next = cnt_reg + 1'b1;
        else if (take && !wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (take)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule
